// ===== rtl/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

  localparam int WIN_DEPTH  = 16;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REP_ALL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] pattern;
    logic [WIN_DEPTH-1:0]      care;
    logic [LEN_W-1:0]          len;
    logic                      report_all;
    logic [ADDR_W-1:0]         base;
  } cfg_t;

endpackage

// ===== rtl/mbps_cfg.sv =====
// Configuration register file for the scanner.
module mbps_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mbps_pkg::cfg_t                    cfg
);
  import mbps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PAT_LO:  cfg_nxt.pattern[7:0]  = cfg_data;
        REG_PAT_HI:  cfg_nxt.pattern[15:8] = cfg_data;
        REG_CARE:    cfg_nxt.care          = cfg_data[WIN_DEPTH-1:0];
        REG_LEN:     cfg_nxt.len           = cfg_data[LEN_W-1:0];
        REG_REP_ALL: cfg_nxt.report_all    = cfg_data[0];
        REG_BASE:    cfg_nxt.base          = cfg_data[ADDR_W-1:0];
        default:     cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pattern: '0, care: '0, len: LEN_RESET, report_all: 1'b0, base: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/mbps_match.sv =====
// Parallel masked compare of the byte window and match address calculation.
module mbps_match #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_BITS  = 32
) (
  input  mbps_pkg::cfg_t               cfg,
  input  mbps_pkg::win_t               win,
  input  logic [COUNT_BITS-1:0]        count,
  output logic                         hit,
  output logic [mbps_pkg::ADDR_W-1:0]  addr
);
  import mbps_pkg::*;

  logic len_ok;
  logic cnt_ok;

  assign len_ok = (cfg.len != '0) && (cfg.len <= LEN_W'(PATTERN_MAX));
  assign cnt_ok = count >= COUNT_BITS'(cfg.len);

  // Pattern byte j lines up with window entry len-1-j (entry 0 is newest).
  always_comb begin
    logic [3:0] idx;
    hit = len_ok && cnt_ok;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      idx = 4'(cfg.len - LEN_W'(1) - LEN_W'(j));
      if ((LEN_W'(j) < cfg.len) && cfg.care[j] && (win[idx] != cfg.pattern[j])) begin
        hit = 1'b0;
      end
    end
  end

  assign addr = cfg.base + (ADDR_W'(count) - ADDR_W'(cfg.len));

endmodule

// ===== rtl/masked_byte_pattern_scanner.sv =====
// Top level of the masked byte pattern scanner: window, pipeline and result register.
//
// Channel   Dir  Handshake          Payload
// in_       in   tvalid/tready      tdata = data_byte, tlast = region_end
// out_      out  tvalid/tready      tdata = match_address, tuser = {any_found, match_valid},
//                                   tlast = region_done
// cfg_      in   valid/ready        index = register number, data = value
//
// One byte per cycle sustained while the output is not stalled: a byte is
// registered into the window, then the window stage compares the whole window
// in parallel and loads the result register.
// Synchronous active-low reset clears the window, byte count, valid and found flags and config.
// An output stall holds one byte in the window stage and then drops in_tready.
module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = 16,
  parameter int COUNT_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // region_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mbps_pkg::ADDR_W-1:0]       out_tdata,  // [47:0] match_address
  output logic [1:0]                        out_tuser,  // [0] match_valid, [1] any_found
  output logic                              out_tlast,  // region_done
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mbps_pkg::*;

  cfg_t cfg;

  // window stage (input register)
  win_t                  win_r;
  logic [COUNT_BITS-1:0] seen_r;
  logic [COUNT_BITS-1:0] seen_inc;
  logic [COUNT_BITS-1:0] a_cnt_r;
  logic                  a_last_r;
  logic                  a_vld_r;

  // found flag of the current region
  logic                  found_r;
  logic                  found_nxt;

  // result register
  logic                  out_vld_r;
  logic                  out_match_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic                  out_last_r;
  logic                  out_any_r;

  logic                  in_acc;
  logic                  a_adv;
  logic                  hit;
  logic                  report;
  logic                  emit;
  logic [ADDR_W-1:0]     match_addr;

  mbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbps_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .COUNT_BITS  (COUNT_BITS)
  ) u_match (
    .cfg   (cfg),
    .win   (win_r),
    .count (a_cnt_r),
    .hit   (hit),
    .addr  (match_addr)
  );

  // Advance the window stage when the result register is free or drains now.
  assign a_adv     = a_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !a_vld_r || a_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Byte count saturates at all ones.
  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + COUNT_BITS'(1);

  // Report every hit in report-all mode, else only the first of the region.
  assign report    = hit && (cfg.report_all || !found_r);
  assign emit      = report || a_last_r;
  assign found_nxt = a_last_r ? 1'b0 : (found_r || hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      seen_r   <= '0;
      a_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        win_r    <= {win_r[WIN_DEPTH-2:0], in_tdata};
        a_cnt_r  <= seen_inc;
        a_last_r <= in_tlast;
        // clear the count after the region's last byte
        seen_r   <= in_tlast ? '0 : seen_inc;
        a_vld_r  <= 1'b1;
      end else if (a_adv) begin
        a_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (a_adv) begin
        found_r   <= found_nxt;
        out_vld_r <= emit;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk) begin
    if (a_adv && emit) begin
      out_match_r <= report;
      out_addr_r  <= report ? match_addr : '0;
      out_last_r  <= a_last_r;
      out_any_r   <= found_r || hit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = {out_any_r, out_match_r};
  assign out_tlast  = out_last_r;

  // A result always carries a match or a region end.
  a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_match_r || out_last_r))
    else $error("empty result");

  // A reported match implies the region found flag.
  a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_match_r) |-> out_any_r)
    else $error("match without found flag");

  // No match means zero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_match_r) |-> (out_addr_r == '0))
    else $error("address set without match");

  // The count restarts after a region's last byte.
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (seen_r == '0))
    else $error("count not cleared at region end");

endmodule

// ===== bench/masked_byte_pattern_scanner_tb.sv =====
// Self-checking bench for the masked byte pattern scanner: random regions, planted patterns.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_tb;
  import mbps_pkg::*;

  // Spare register indexes: writes there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 6;   // covers the window and result registers plus margin
  localparam int RANDOM_BYTES = 600;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_REPORTS = 30;

  // One byte request as the driver presents it.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } scan_byte_t;

  // One result: a reported match and/or the end-of-region summary.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic              done;
    logic              found;
  } scan_report_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [ADDR_W-1:0]     out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  masked_byte_pattern_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Scanner model: its own registers, window, byte count and found flag.
  // ---------------------------------------------------------------------------
  cfg_t         model_cfg;
  logic [7:0]   model_win [WIN_DEPTH];
  logic [31:0]  model_seen;
  logic         model_found;

  scan_byte_t   scan_bytes_q [$];
  scan_report_t expected_reports_q [$];

  int           fault_count = 0;
  int           bytes_queued = 0;
  int           bytes_taken = 0;
  int           cycle_count = 0;
  logic         in_taken = 1'b0;

  // Shift one accepted byte into the window and queue the result it causes, if any.
  function automatic void predict_scan_step(input logic [7:0] b, input logic last);
    scan_report_t r;
    logic         hit;
    logic         report;
    int           len;
    for (int k = WIN_DEPTH - 1; k > 0; k--) model_win[k] = model_win[k - 1];
    model_win[0] = b;
    // Saturate the count instead of wrapping.
    if (model_seen != '1) model_seen = model_seen + 1;
    len = model_cfg.len;
    // Lengths of zero or beyond the window never match; a short region cannot either.
    hit = (len >= 1) && (len <= WIN_DEPTH) && (model_seen >= 32'(len));
    if (hit) begin
      for (int j = 0; j < len; j++) begin
        if (model_cfg.care[j] && model_win[len - 1 - j] != model_cfg.pattern[j]) hit = 1'b0;
      end
    end
    // First-match mode drops every later hit of the same region.
    report = hit && (model_cfg.report_all || !model_found);
    if (hit) model_found = 1'b1;
    r.hit   = report;
    r.addr  = report ? model_cfg.base + ADDR_W'(model_seen - 32'(len)) : '0;
    r.done  = last;
    r.found = model_found;
    if (report || last) expected_reports_q = {expected_reports_q, r};
    if (last) begin
      model_seen  = '0;
      model_found = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [ADDR_W-1:0] want,
                                      input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted byte request, check every accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    scan_report_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_scan_step(in_tdata, in_tlast);
      bytes_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual addr=%h user=%b last=%b",
                   $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_reports_q.pop_front();
        check_field("match_valid", ADDR_W'(want.hit), ADDR_W'(out_tuser[0]));
        check_field("match_address", want.addr, out_tdata);
        check_field("region_done", ADDR_W'(want.done), ADDR_W'(out_tlast));
        check_field("any_found", ADDR_W'(want.found), ADDR_W'(out_tuser[1]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes in bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    int         burst_left;
    int         gap_left;
    logic       v;
    scan_byte_t item;
    v = in_tvalid;
    item = {in_tlast, in_tdata};
    if (!rst_n) begin
      v = 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      // Drop the request that went through at the last rising edge.
      if (in_taken) v = 1'b0;
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (scan_bytes_q.size() != 0) begin
          item = scan_bytes_q.pop_front();
          v = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; half of them follow without any gap.
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_tvalid <= v;
    in_tdata  <= item.data;
    in_tlast  <= item.last;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a rotating ready pattern, reloaded after each full rotation.
  // Twice in the run, hold off for a long stretch so the scanner backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    logic [15:0] rdy_pat;
    int          pat_step;
    int          hold_left;
    int          holds_done;
    logic        r;
    if (!rst_n) begin
      rdy_pat = '1;
      pat_step = 0;
      hold_left = 0;
      holds_done = 0;
      r = 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        r = 1'b0;
      end else if (holds_done < 2 && bytes_taken >= 250 + 200 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        r = 1'b0;
      end else begin
        r = rdy_pat[0];
      end
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      pat_step = (pat_step + 1) % 16;
      if (pat_step == 0) begin
        case ($urandom_range(0, 3))
          0: rdy_pat = '1;
          1: rdy_pat = 16'($urandom);
          2: rdy_pat = 16'($urandom) | 16'($urandom);
          default: rdy_pat = 16'($urandom) & 16'($urandom);
        endcase
      end
    end
    out_tready <= r;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_reports_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Write one register; mirror it into the model once the request is accepted.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PAT_LO:  model_cfg.pattern[7:0]  = val;
      REG_PAT_HI:  model_cfg.pattern[15:8] = val;
      REG_CARE:    model_cfg.care          = val[WIN_DEPTH-1:0];
      REG_LEN:     model_cfg.len           = val[LEN_W-1:0];
      REG_REP_ALL: model_cfg.report_all    = val[0];
      REG_BASE:    model_cfg.base          = val[ADDR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    scan_byte_t item;
    item.last = last;
    item.data = b;
    scan_bytes_q = {scan_bytes_q, item};
    bytes_queued++;
  endtask

  // Wait until every byte went in and every expected result came out, then
  // let the pipeline settle so no byte without a result is still in flight.
  task automatic drain();
    while (scan_bytes_q.size() != 0 || in_tvalid || expected_reports_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue a region of n bytes; plant the pattern now and then, fill the rest
  // partly with pattern bytes so near misses are common.
  task automatic queue_region(input int n, input bit close);
    int         k;
    int         plen;
    logic [7:0] b;
    plen = (model_cfg.len == 0) ? 1 : (model_cfg.len > WIN_DEPTH ? WIN_DEPTH : model_cfg.len);
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 3) == 0 && k + plen <= n) begin
        for (int j = 0; j < plen; j++) begin
          b = model_cfg.care[j] ? model_cfg.pattern[j] : 8'($urandom);
          queue_byte(b, close && k == n - 1);
          k++;
        end
      end else begin
        b = $urandom_range(0, 1) ? 8'($urandom) : model_cfg.pattern[$urandom_range(0, 15)];
        queue_byte(b, close && k == n - 1);
        k++;
      end
    end
  endtask

  // Pick and write a full random setup; lengths lean short so hits are common.
  task automatic program_random_setup();
    logic [15:0]       care;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] base;
    int                pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)       len = LEN_W'($urandom_range(1, 4));
    else if (pick < 8)  len = LEN_W'($urandom_range(5, WIN_DEPTH));
    else if (pick == 8) len = LEN_W'(WIN_DEPTH);
    else                len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    case ($urandom_range(0, 4))
      0:       care = '1;
      1:       care = '0;
      2:       care = 16'($urandom);
      default: care = 16'($urandom) & 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = '1;
      default: base = {16'($urandom), 32'($urandom)};
    endcase
    write_reg(REG_PAT_LO, {$urandom, $urandom});
    write_reg(REG_PAT_HI, {$urandom, $urandom});
    write_reg(REG_CARE, {16'($urandom), 32'($urandom), care});
    write_reg(REG_LEN, {27'($urandom), 32'($urandom), len});
    write_reg(REG_REP_ALL, {32'($urandom), 31'($urandom), 1'($urandom_range(0, 1))});
    write_reg(REG_BASE, {16'($urandom), base});
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed cases, then random setups and regions.
  // ---------------------------------------------------------------------------
  initial begin
    model_cfg = '0;
    model_cfg.len = LEN_RESET;
    for (int k = 0; k < WIN_DEPTH; k++) model_win[k] = '0;
    model_seen = '0;
    model_found = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pattern DE AD BE EF, all four bytes cared for, first match only,
    // base one below the top of the address range.
    write_reg(REG_PAT_LO, 64'h0000_0000_EFBE_ADDE);
    write_reg(REG_PAT_HI, '1);
    write_reg(REG_CARE, 64'h0000_0000_0000_000F);
    write_reg(REG_LEN, 64'd4);
    write_reg(REG_REP_ALL, '0);
    write_reg(REG_BASE, 64'h0000_FFFF_FFFF_FFFE);
    // Spare indexes change nothing.
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);

    // Short region: ends before a match is possible.
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b1);
    // Two back-to-back matches; first-match mode reports only the first.
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'hEF, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'hEF, 1'b1);
    drain();

    // Wildcards on bytes 1 and 3, every match reported, base at the top.
    // Leave the region open across the next setup change.
    write_reg(REG_REP_ALL, '1);
    write_reg(REG_CARE, 64'h0000_0000_0000_0005);
    write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'h22, 1'b0);
    drain();

    // Length zero never matches, even mid-region with the window full.
    write_reg(REG_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'hFF, 1'b1);
    drain();

    // Length beyond the window never matches either.
    write_reg(REG_LEN, 64'd31);
    queue_byte(8'hFF, 1'b1);
    drain();

    // Random part: sometimes leave the last region open into the next setup.
    bytes_queued = 0;
    while (bytes_queued < RANDOM_BYTES) begin
      program_random_setup();
      repeat ($urandom_range(2, 6))
        queue_region($urandom_range(0, 9) == 0 ? $urandom_range(25, 60) : $urandom_range(1, 20),
                     1'b1);
      queue_region($urandom_range(1, 20), $urandom_range(0, 3) != 0);
      drain();
    end

    if (fault_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
